// ----- sv/dss_pkg.sv -----
// Shared types, constants and segment table of the seven-segment serializer.
package dss_pkg;

  localparam int NUM_DIGITS = 6;
  localparam int NUM_CHAINS = 3;

  localparam int VAL_W   = 17;
  localparam int CHAIN_W = 2;
  localparam int SEG_W   = 8;
  localparam int BIT_W   = 3;
  localparam int POS_W   = $clog2(NUM_DIGITS);
  localparam int WORK_W  = 32;

  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(SEG_W - 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_DIGITS - 1);

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
  localparam logic [SEG_W-1:0] SEG_POINT = 8'h01;

  typedef logic [NUM_DIGITS-1:0][WORK_W-1:0] weight_tab_t;

  // Entry p holds the decimal weight of position p: 10**(NUM_DIGITS-1-p).
  function automatic weight_tab_t build_weights();
    weight_tab_t tab;
    logic [WORK_W-1:0] w;
    w = WORK_W'(1);
    for (int p = NUM_DIGITS - 1; p >= 0; p--) begin
      tab[p] = w;
      w = WORK_W'(w * WORK_W'(10));
    end
    return tab;
  endfunction

  localparam weight_tab_t WEIGHT = build_weights();
  localparam logic [WORK_W-1:0] SAT_LIMIT = WEIGHT[0] - WORK_W'(1);

  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
    logic [SEG_W-1:0] seg;
    unique case (digit)
      4'd0:    seg = 8'hFC;
      4'd1:    seg = 8'h60;
      4'd2:    seg = 8'hDA;
      4'd3:    seg = 8'hF2;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'hB6;
      4'd6:    seg = 8'hBE;
      4'd7:    seg = 8'hE4;
      4'd8:    seg = 8'hFE;
      4'd9:    seg = 8'hF6;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

  typedef struct packed {
    logic [VAL_W-1:0]   value;
    logic [CHAIN_W-1:0] chain;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] rem;
    logic             lead;
  } enc_req_t;

  typedef struct packed {
    logic [SEG_W-1:0] seg;
    logic [VAL_W-1:0] rem;
    logic             lead;
  } enc_rsp_t;

endpackage

// ----- sv/dss_in_if.sv -----
// Input channel: value and chain number with valid/ready.
interface dss_in_if
  import dss_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VAL_W-1:0]   value;
  logic [CHAIN_W-1:0] chain;

  modport source (output valid, output value, output chain, input ready);
  modport sink   (input valid, input value, input chain, output ready);
endinterface

// ----- sv/dss_out_if.sv -----
// Output channel: one serialized segment bit per word with valid/ready.
interface dss_out_if
  import dss_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CHAIN_W-1:0] chain_out;
  logic               data_bit;
  logic               last;

  modport source (output valid, output chain_out, output data_bit, output last, input ready);
  modport sink   (input valid, input chain_out, input data_bit, input last, output ready);
endinterface

// ----- sv/dss_in_stage.sv -----
// Input holding register: drop unused chains, saturate, hold one word.
module dss_in_stage
  import dss_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  dss_in_if.sink  in_i,
  input  logic    take_i,
  output logic    hold_valid_o,
  output item_t   hold_o
);

  logic  hold_valid_q, hold_valid_d;
  item_t hold_q, hold_d;
  logic  accept;
  logic  chain_ok;

  assign in_i.ready = !hold_valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;
  assign chain_ok   = int'(in_i.chain) < NUM_CHAINS;

  always_comb begin
    hold_d       = hold_q;
    hold_valid_d = hold_valid_q && !take_i;
    if (accept && chain_ok) begin
      hold_valid_d = 1'b1;
      hold_d.chain = in_i.chain;
      hold_d.value = (WORK_W'(in_i.value) > SAT_LIMIT) ? SAT_LIMIT[VAL_W-1:0] : in_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

  assign hold_valid_o = hold_valid_q;
  assign hold_o       = hold_q;

endmodule

// ----- sv/dss_digit_enc.sv -----
// Digit encoder: extract one decimal digit, blank or mark it, map to segments.
module dss_digit_enc
  import dss_pkg::*;
(
  input  enc_req_t req_i,
  output enc_rsp_t rsp_o
);

  logic [WORK_W-1:0] rem_w;
  logic [WORK_W-1:0] step_w;
  logic [3:0]        digit;
  logic              blank;
  logic              point;

  // Restoring division by the position weight: four compare-subtract steps.
  always_comb begin
    rem_w  = WORK_W'(req_i.rem);
    step_w = '0;
    digit  = '0;
    for (int k = 3; k >= 0; k--) begin
      step_w = WEIGHT[req_i.pos] << k;
      if (rem_w >= step_w) begin
        rem_w    = rem_w - step_w;
        digit[k] = 1'b1;
      end
    end
  end

  assign blank = (int'(req_i.pos) < NUM_DIGITS - 2) && req_i.lead && (digit == 4'd0);
  assign point = int'(req_i.pos) == NUM_DIGITS - 2;

  always_comb begin
    rsp_o.rem  = rem_w[VAL_W-1:0];
    rsp_o.lead = blank;
    if (blank) begin
      rsp_o.seg = SEG_BLANK;
    end else begin
      rsp_o.seg = seg_code(digit) | (point ? SEG_POINT : SEG_BLANK);
    end
  end

endmodule

// ----- sv/dss_frame_shift.sv -----
// Frame shifter: load one segment byte per position, shift it out MSB first.
module dss_frame_shift
  import dss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      hold_valid_i,
  input  item_t     hold_i,
  output logic      take_o,
  dss_out_if.source out_o
);

  logic               busy_q, busy_d;
  logic [CHAIN_W-1:0] chain_q, chain_d;
  logic [VAL_W-1:0]   rem_q, rem_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [SEG_W-1:0]   byte_q, byte_d;
  logic               lead_q, lead_d;
  logic               fire;
  logic               frame_end;
  enc_req_t           enc_req;
  enc_rsp_t           enc_rsp;

  assign enc_req.pos  = pos_q + POS_W'(1);
  assign enc_req.rem  = rem_q;
  assign enc_req.lead = lead_q;

  dss_digit_enc u_enc (
    .req_i (enc_req),
    .rsp_o (enc_rsp)
  );

  assign fire      = busy_q && out_o.ready;
  assign frame_end = (pos_q == POS_LAST) && (bit_q == BIT_LAST);

  always_comb begin
    busy_d  = busy_q;
    chain_d = chain_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    lead_d  = lead_q;
    take_o  = 1'b0;
    priority if (fire && (bit_q != BIT_LAST)) begin
      byte_d = {byte_q[SEG_W-2:0], 1'b0};
      bit_d  = bit_q + BIT_W'(1);
    end else if (fire && !frame_end) begin
      pos_d  = pos_q + POS_W'(1);
      bit_d  = '0;
      byte_d = enc_rsp.seg;
      rem_d  = enc_rsp.rem;
      lead_d = enc_rsp.lead;
    end else if (!busy_q || fire) begin
      busy_d = hold_valid_i;
      if (hold_valid_i) begin
        take_o  = 1'b1;
        chain_d = hold_i.chain;
        rem_d   = hold_i.value;
        pos_d   = '0;
        bit_d   = '0;
        byte_d  = SEG_BLANK;
        lead_d  = 1'b1;
      end
    end else begin
      busy_d = busy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
      bit_q  <= '0;
      lead_q <= 1'b1;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
      bit_q  <= bit_d;
      lead_q <= lead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chain_q <= chain_d;
    rem_q   <= rem_d;
    byte_q  <= byte_d;
  end

  assign out_o.valid     = busy_q;
  assign out_o.chain_out = chain_q;
  assign out_o.data_bit  = byte_q[SEG_W-1];
  assign out_o.last      = frame_end;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (int'(pos_q) <= NUM_DIGITS - 1))
    else $error("position counter past last digit");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && frame_end) |=> (!busy_q || ((pos_q == '0) && (bit_q == '0))))
    else $error("frame did not restart at first position");

  a_first_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (pos_q == '0)) |-> (byte_q == SEG_BLANK))
    else $error("leftmost position not blank");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !out_o.ready) |=> (busy_q && $stable(byte_q) && $stable(pos_q) && $stable(bit_q)))
    else $error("shifter advanced while stalled");

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |-> (hold_valid_i && (!busy_q || (fire && frame_end))))
    else $error("item taken while a frame is in flight");

endmodule

// ----- sv/decimal_seven_segment_serializer.sv -----
// An accepted word passes the holding register and then loads into the shifter to show its first bit.
// Throughput: one frame of NUM_DIGITS*8 bits (48) per input word, one bit per cycle while output
//   ready is high, set by the single segment shift register; one further word waits in the holding stage.
// Words naming a chain of NUM_CHAINS or more are accepted and produce no output.
// Reset (rst_ni low, asynchronous) empties the holding stage and the shifter;
//   data registers keep their contents and are ignored until reloaded.
module decimal_seven_segment_serializer
  import dss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  dss_in_if.sink    in_i,
  dss_out_if.source out_o
);

  // Handoff between the holding stage and the frame shifter.
  logic  hold_valid;
  item_t hold;
  logic  take;

  // Hold one incoming word: saturate the value to what the digits can show,
  // drop words for chains that do not exist, and release the word to the
  // shifter when it asks for it. A new word is taken in the same cycle the
  // held one moves on, so the input never waits on an idle slot.
  dss_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .take_i       (take),
    .hold_valid_o (hold_valid),
    .hold_o       (hold)
  );

  // Shift out the frame: the leftmost position is always blank, then each
  // position's digit is peeled off the running remainder by its decimal
  // weight, leading zeros above the point position are blanked, the point
  // is lit on the tenths-to-units boundary, and each byte goes out MSB first.
  // The next held word loads at the same edge that takes the last bit, so
  // frames follow each other with no gap.
  dss_frame_shift u_frame_shift (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hold_valid_i (hold_valid),
    .hold_i       (hold),
    .take_o       (take),
    .out_o        (out_o)
  );

endmodule

// ----- sim/tb.sv -----
// Testbench for decimal_seven_segment_serializer: drives values, predicts and checks every bit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dss_pkg::*;

  // Segment byte of each decimal digit, index 0 at the right of the concatenation.
  localparam logic [9:0][SEG_W-1:0] DIGIT_GLYPH = {
    8'hF6, 8'hFE, 8'hE4, 8'hBE, 8'hB6, 8'h66, 8'hF2, 8'hDA, 8'h60, 8'hFC
  };
  // Largest number that fits in the positions right of the blank one.
  localparam int unsigned SHOW_MAX = 10 ** (NUM_DIGITS - 1) - 1;
  localparam int unsigned FRAME_BITS = NUM_DIGITS * SEG_W;
  localparam int unsigned WORDS_PER_PHASE = 75;
  localparam int unsigned QUIET_CYCLES = 20;
  localparam int unsigned REPORT_LIMIT = 10;

  // One serialized segment bit as the block should emit it.
  typedef struct packed {
    logic [CHAIN_W-1:0] chain;
    logic               data_bit;
    logic               last;
  } seg_bit_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dss_in_if  in_if ();
  dss_out_if out_if ();

  decimal_seven_segment_serializer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  item_t       word_q[$];          // words waiting for the driver
  seg_bit_t    expected_bits_q[$]; // predicted frame bits, oldest first
  int unsigned words_queued = 0;
  int unsigned words_taken = 0;
  int unsigned error_count = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        in_taken = 1'b0;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Work out the 48 bits one display word produces and append them to the
  // expected store. A chain beyond the last one lights nothing.
  function automatic void predict_frame_bits(input logic [VAL_W-1:0] value,
                                             input logic [CHAIN_W-1:0] chain);
    int unsigned      shown;
    logic [3:0]       digit [NUM_DIGITS];
    logic [SEG_W-1:0] glyph [NUM_DIGITS];
    logic             leading;
    seg_bit_t         sb;
    if (chain >= CHAIN_W'(NUM_CHAINS)) return;
    // Clamp to what the display can hold.
    shown = (value > SHOW_MAX) ? SHOW_MAX : int'(value);
    digit[0] = 4'd0;
    for (int p = NUM_DIGITS - 1; p >= 1; p--) begin
      digit[p] = 4'(shown % 10);
      shown = shown / 10;
    end
    // Leftmost position stays dark; leading zeros go dark up to the position
    // left of the point, which always shows its digit plus the point.
    glyph[0] = SEG_BLANK;
    leading = 1'b1;
    for (int p = 1; p < NUM_DIGITS; p++) begin
      if (p < NUM_DIGITS - 2 && leading && digit[p] == 4'd0) begin
        glyph[p] = SEG_BLANK;
      end else begin
        leading = 1'b0;
        glyph[p] = DIGIT_GLYPH[digit[p]];
        if (p == NUM_DIGITS - 2) glyph[p] = glyph[p] | SEG_POINT;
      end
    end
    // Shift out leftmost position first, MSB first.
    for (int p = 0; p < NUM_DIGITS; p++) begin
      for (int b = 0; b < SEG_W; b++) begin
        sb.chain    = chain;
        sb.data_bit = glyph[p][SEG_W-1-b];
        sb.last     = (p == NUM_DIGITS - 1 && b == SEG_W - 1);
        expected_bits_q.push_back(sb);
      end
    end
  endfunction

  // Count a failure; print only the first few.
  function automatic void flag_error(input string what, input seg_bit_t want,
                                     input seg_bit_t got);
    error_count++;
    if (error_count <= REPORT_LIMIT)
      $display("%t: %s: expected chain=%0d bit=%0b last=%0b, got chain=%0d bit=%0b last=%0b",
               $realtime, what, want.chain, want.data_bit, want.last,
               got.chain, got.data_bit, got.last);
  endfunction

  // Monitor: sample both channels at the rising edge. Accepted input words
  // feed the predictor; accepted output words are checked against the oldest
  // expected bit.
  always @(posedge clk_i) begin
    seg_bit_t got;
    seg_bit_t want;
    in_taken = rst_ni && in_if.valid && in_if.ready;
    if (in_taken) begin
      predict_frame_bits(in_if.value, in_if.chain);
      words_taken++;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.chain    = out_if.chain_out;
      got.data_bit = out_if.data_bit;
      got.last     = out_if.last;
      if (expected_bits_q.size() == 0) begin
        flag_error("unexpected word", '0, got);
      end else begin
        want = expected_bits_q.pop_front();
        if (got !== want) flag_error("mismatch", want, got);
      end
    end
  end

  // Driver: change inputs at the falling edge. Hold a word until it is taken,
  // then advance to the next pending one or idle at random.
  always @(negedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (word_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        in_if.value <= word_q[0].value;
        in_if.chain <= word_q[0].chain;
        in_if.valid <= 1'b1;
        void'(word_q.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  task automatic queue_word(input int unsigned value, input int unsigned chain);
    item_t w;
    w.value = VAL_W'(value);
    w.chain = CHAIN_W'(chain);
    word_q.push_back(w);
    words_queued++;
  endtask

  // Hold the sender until every queued word is taken and every bit has come.
  task automatic wait_until_drained();
    while (words_taken != words_queued || expected_bits_q.size() != 0)
      @(negedge clk_i);
  endtask

  // Mix small, mid-size, saturating and full-range values, and values next to powers of ten.
  function automatic int unsigned pick_value();
    int unsigned pow;
    case ($urandom_range(5))
      0: return $urandom_range(99);
      1: return $urandom_range(9999);
      2: return $urandom_range(SHOW_MAX);
      3: return $urandom_range(SHOW_MAX - 10, (1 << VAL_W) - 1);
      4: return $urandom & ((1 << VAL_W) - 1);
      default: begin
        pow = 1;
        repeat ($urandom_range(NUM_DIGITS - 1)) pow = pow * 10;
        return pow + $urandom_range(2) - 1;
      end
    endcase
  endfunction

  initial begin
    int unsigned gap_pct [4];
    int unsigned stall_pct [4];
    int unsigned lit;
    int unsigned chain;
    gap_pct   = '{0, 55, 0, 20};
    stall_pct = '{0, 0, 55, 20};

    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.value = '0;
    in_if.chain = '0;
    out_if.ready = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: zero, values below ten, digit boundaries, every digit glyph,
    // interior zeros, saturation and the out-of-range chain.
    queue_word(0, 0);
    queue_word(1, 1);
    queue_word(9, 2);
    queue_word(10, 0);
    queue_word(99, 1);
    queue_word(100, 2);
    queue_word(1000, 0);
    queue_word(10000, 1);
    queue_word(12345, 2);
    queue_word(67890, 0);
    queue_word(10203, 1);
    queue_word(98765, 2);
    queue_word(99999, 0);
    queue_word(100000, 1);
    queue_word((1 << VAL_W) - 1, 2);
    queue_word((1 << VAL_W) - 1, 3);
    queue_word(0, 3);
    queue_word(4, 0);
    queue_word(50607, 1);
    queue_word(65536, 2);
    wait_until_drained();

    // Random phases; the drain between them is also the sender pause.
    for (int ph = 0; ph < 4; ph++) begin
      send_gap_pct = gap_pct[ph];
      recv_stall_pct = stall_pct[ph];
      lit = 0;
      while (lit < WORDS_PER_PHASE) begin
        chain = ($urandom_range(9) == 0) ? NUM_CHAINS : $urandom_range(NUM_CHAINS - 1);
        if (chain < NUM_CHAINS) lit++;
        queue_word(pick_value(), chain);
      end
      wait_until_drained();
    end

    // Let any stray word from an unlit frame show up.
    repeat (QUIET_CYCLES + FRAME_BITS) @(negedge clk_i);
    if (error_count == 0 && expected_bits_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #800us;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
